// File: sv/polarization_product_detector_unit_defines.svh
// Assertion macros of the polarization product detector top level.
`ifndef POLARIZATION_PRODUCT_DETECTOR_UNIT_DEFINES_SVH
`define POLARIZATION_PRODUCT_DETECTOR_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// Check that an implication holds at every clock edge outside reset.
`define PPD_ASSERT_PROP(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that a condition never holds outside reset.
`define PPD_ASSERT_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`else

`define PPD_ASSERT_PROP(lbl, clk, rst, prop, msg)
`define PPD_ASSERT_NEVER(lbl, clk, rst, cond, msg)

`endif

`endif

// File: sv/ppd_pkg.sv
// Types, constants and helpers of the polarization product detector.
package ppd_pkg;

   localparam int SAMPLE_WIDTH_DEF = 16;
   localparam int FIELD_W          = 16;
   // A sample is at most 17 significant bits; sums of two take 18.
   localparam int OP_W             = FIELD_W + 2;
   localparam int PROD_W           = 2 * OP_W;
   localparam int SUM_W            = PROD_W + 2;
   localparam int VALUE_W          = 34;
   localparam int KIND_W           = 3;
   localparam int MAX_RESULTS      = 4;
   localparam int CNT_W            = $clog2(MAX_RESULTS + 1);
   localparam int MODE_W           = 2;
   localparam int CSR_ADDR_W       = 3;
   localparam int CSR_DATA_W       = 32;

   typedef logic [MODE_W-1:0] mode_type;
   typedef logic [KIND_W-1:0] kind_type;

   localparam mode_type MODE_INTENSITY = 2'd0;
   localparam mode_type MODE_LINEAR    = 2'd1;
   localparam mode_type MODE_CIRCULAR  = 2'd2;
   localparam mode_type MODE_STOKES    = 2'd3;
   localparam mode_type MODE_RESET     = MODE_STOKES;

   localparam kind_type KIND_I  = 3'd0;
   localparam kind_type KIND_Q  = 3'd1;
   localparam kind_type KIND_U  = 3'd2;
   localparam kind_type KIND_V  = 3'd3;
   localparam kind_type KIND_XX = 3'd4;
   localparam kind_type KIND_YY = 3'd5;
   localparam kind_type KIND_LL = 3'd6;
   localparam kind_type KIND_RR = 3'd7;

   // Register index of product_mode.
   localparam logic REG_PRODUCT_MODE = 1'b0;

   localparam logic signed [SUM_W-1:0] VALUE_HI =
      SUM_W'((64'sd1 <<< (VALUE_W - 1)) - 64'sd1);
   localparam logic signed [SUM_W-1:0] VALUE_LO = -VALUE_HI - SUM_W'(1);

   // One detected item set: up to four results of a single sample.
   typedef struct packed {
      logic                                 valid;
      logic [CNT_W-1:0]                     count;
      logic [MAX_RESULTS-1:0][VALUE_W-1:0]  value;
      logic [MAX_RESULTS-1:0][KIND_W-1:0]   kind;
   } result_set_type;

   // Saturate a wide sum to the signed output range.
   function automatic logic [VALUE_W-1:0] clamp_value(input logic signed [SUM_W-1:0] v);
      if (v > VALUE_HI) begin
         return VALUE_HI[VALUE_W-1:0];
      end else if (v < VALUE_LO) begin
         return VALUE_LO[VALUE_W-1:0];
      end else begin
         return v[VALUE_W-1:0];
      end
   endfunction

endpackage

// File: sv/polarization_product_detector_unit.sv
// Top level of the polarization product detector: register port, pipeline, output buffer.
//
//   channel  direction  handshake                  contents
//   req      in         req_tvalid / req_tready    one X/Y sample pair per item
//   rsp      out        rsp_tvalid / rsp_tready    one detected product per item
//   csr      in/out     APB write, pready high     product_mode at address 0
//
// A sample produces 1 (intensity), 2 (linear, circular) or 4 (Stokes) results, and the
// single result port issues one per cycle while rsp_tready is high; the results are
// registered through the pipeline stages and the output buffer before they appear.
// Reset empties the pipeline and the output buffer and sets product_mode to Stokes.
// While the output buffer cannot take the results held in stage 5, the whole pipeline
// holds and req_tready is low.
`include "polarization_product_detector_unit_defines.svh"

module polarization_product_detector_unit #(
   parameter int SAMPLE_WIDTH = ppd_pkg::SAMPLE_WIDTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // x_real [15:0], x_imag [31:16], y_real [47:32], y_imag [63:48]
   input  logic [4*ppd_pkg::FIELD_W-1:0]       req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // power_value [33:0], zero fill [39:34]
   output logic [39:0]                         rsp_tdata,
   // product_kind [2:0]
   output logic [ppd_pkg::KIND_W-1:0]          rsp_tuser,
   // run_last
   output logic                                rsp_tlast,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [ppd_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [ppd_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [ppd_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                csr_pready
);

   ppd_pkg::mode_type         mode_ff;
   ppd_pkg::result_set_type   result_set;
   logic [3:0][ppd_pkg::FIELD_W-1:0] in_fields;
   logic                      advance, ser_ready, csr_write, reg_sel;
   logic [ppd_pkg::VALUE_W-1:0] out_value;
   ppd_pkg::kind_type         out_kind;

   // csr: one register, index taken from the word address
   assign csr_pready = 1'b1;
   assign reg_sel    = (csr_paddr[2] == ppd_pkg::REG_PRODUCT_MODE);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= ppd_pkg::MODE_RESET;
      end else if (csr_write && reg_sel) begin
         mode_ff <= csr_pwdata[ppd_pkg::MODE_W-1:0];
      end
   end

   assign csr_prdata = reg_sel ? ppd_pkg::CSR_DATA_W'(mode_ff) : '0;

   assign in_fields  = req_tdata;
   assign advance    = !result_set.valid || ser_ready;
   assign req_tready = advance;

   ppd_datapath #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .in_valid   (req_tvalid),
      .in_fields  (in_fields),
      .mode       (mode_ff),
      .result_set (result_set)
   );

   ppd_serializer u_serializer (
      .clock      (clock),
      .reset      (reset),
      .result_set (result_set),
      .ready      (ser_ready),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_value  (out_value),
      .out_kind   (out_kind),
      .out_last   (rsp_tlast)
   );

   assign rsp_tdata = {{(40 - ppd_pkg::VALUE_W){1'b0}}, out_value};
   assign rsp_tuser = out_kind;

   `PPD_ASSERT_PROP(a_run_continues, clock, reset, rsp_tvalid && rsp_tready && !rsp_tlast |=> rsp_tvalid, "result run broken before its last item")
   `PPD_ASSERT_NEVER(a_intensity_single, clock, reset, rsp_tvalid && (mode_ff == ppd_pkg::MODE_INTENSITY) && !rsp_tlast, "intensity result not marked last")
   `PPD_ASSERT_NEVER(a_stokes_i_first, clock, reset, rsp_tvalid && (mode_ff == ppd_pkg::MODE_STOKES) && (out_kind == ppd_pkg::KIND_I) && rsp_tlast, "Stokes I marked last")

endmodule

// File: sv/ppd_datapath.sv
// Five-stage pipeline: sample extraction, circular sums, products, sums, selection.
module ppd_datapath #(
   parameter int SAMPLE_WIDTH = ppd_pkg::SAMPLE_WIDTH_DEF
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       advance,
   input  logic                                       in_valid,
   input  logic [3:0][ppd_pkg::FIELD_W-1:0]           in_fields,
   input  ppd_pkg::mode_type                          mode,
   output ppd_pkg::result_set_type                    result_set
);

   localparam int OP_W   = ppd_pkg::OP_W;
   localparam int PROD_W = ppd_pkg::PROD_W;
   localparam int SUM_W  = ppd_pkg::SUM_W;

   // stage 1: samples xr, xi, yr, yi, sign-extended (zero-extended when SAMPLE_WIDTH exceeds the field)
   logic                        s1_valid_ff;
   logic signed [OP_W-1:0]      s1_op_ff [4];
   logic signed [OP_W-1:0]      s1_op_in [4];

   for (genvar g = 0; g < 4; g++) begin : g_extract
      if (SAMPLE_WIDTH > ppd_pkg::FIELD_W) begin : g_wide
         // The port holds fewer bits than a sample: upper bits read as zero.
         assign s1_op_in[g] = signed'({{(OP_W - ppd_pkg::FIELD_W){1'b0}}, in_fields[g]});
      end else begin : g_narrow
         assign s1_op_in[g] = signed'({{(OP_W - SAMPLE_WIDTH){in_fields[g][SAMPLE_WIDTH-1]}},
                                       in_fields[g][SAMPLE_WIDTH-1:0]});
      end
   end

   // stage 2: samples plus the circular basis components
   logic                        s2_valid_ff;
   logic signed [OP_W-1:0]      s2_op_ff [4];
   logic signed [OP_W-1:0]      s2_la_ff, s2_lb_ff, s2_ra_ff, s2_rb_ff;

   // stage 3: products
   logic                        s3_valid_ff;
   logic signed [PROD_W-1:0]    s3_xrxr_ff, s3_xixi_ff, s3_yryr_ff, s3_yiyi_ff;
   logic signed [PROD_W-1:0]    s3_xryr_ff, s3_xiyi_ff, s3_xiyr_ff, s3_xryi_ff;
   logic signed [PROD_W-1:0]    s3_lala_ff, s3_lblb_ff, s3_rara_ff, s3_rbrb_ff;

   // stage 4: sums
   logic                        s4_valid_ff;
   logic signed [SUM_W-1:0]     s4_px_ff, s4_py_ff, s4_re_ff, s4_im_ff;
   logic signed [SUM_W-1:0]     s4_lm_ff, s4_rm_ff;

   // stage 5: selected results
   ppd_pkg::result_set_type     s5_ff;
   ppd_pkg::result_set_type     s5_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_ff.valid <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;

         s1_op_ff   <= s1_op_in;

         s2_op_ff   <= s1_op_ff;
         // X + iY = (xr - yi) + i(xi + yr); X - iY = (xr + yi) + i(xi - yr)
         s2_la_ff   <= s1_op_ff[0] - s1_op_ff[3];
         s2_lb_ff   <= s1_op_ff[1] + s1_op_ff[2];
         s2_ra_ff   <= s1_op_ff[0] + s1_op_ff[3];
         s2_rb_ff   <= s1_op_ff[1] - s1_op_ff[2];

         s3_xrxr_ff <= s2_op_ff[0] * s2_op_ff[0];
         s3_xixi_ff <= s2_op_ff[1] * s2_op_ff[1];
         s3_yryr_ff <= s2_op_ff[2] * s2_op_ff[2];
         s3_yiyi_ff <= s2_op_ff[3] * s2_op_ff[3];
         s3_xryr_ff <= s2_op_ff[0] * s2_op_ff[2];
         s3_xiyi_ff <= s2_op_ff[1] * s2_op_ff[3];
         s3_xiyr_ff <= s2_op_ff[1] * s2_op_ff[2];
         s3_xryi_ff <= s2_op_ff[0] * s2_op_ff[3];
         s3_lala_ff <= s2_la_ff * s2_la_ff;
         s3_lblb_ff <= s2_lb_ff * s2_lb_ff;
         s3_rara_ff <= s2_ra_ff * s2_ra_ff;
         s3_rbrb_ff <= s2_rb_ff * s2_rb_ff;

         s4_px_ff   <= SUM_W'(s3_xrxr_ff) + SUM_W'(s3_xixi_ff);
         s4_py_ff   <= SUM_W'(s3_yryr_ff) + SUM_W'(s3_yiyi_ff);
         s4_re_ff   <= SUM_W'(s3_xryr_ff) + SUM_W'(s3_xiyi_ff);
         s4_im_ff   <= SUM_W'(s3_xiyr_ff) - SUM_W'(s3_xryi_ff);
         s4_lm_ff   <= SUM_W'(s3_lala_ff) + SUM_W'(s3_lblb_ff);
         s4_rm_ff   <= SUM_W'(s3_rara_ff) + SUM_W'(s3_rbrb_ff);

         s5_ff      <= s5_in;
      end
   end

   always_comb begin
      s5_in       = '0;
      s5_in.valid = s4_valid_ff;
      unique case (mode)
         ppd_pkg::MODE_INTENSITY: begin
            s5_in.count    = ppd_pkg::CNT_W'(1);
            s5_in.value[0] = ppd_pkg::clamp_value(s4_px_ff + s4_py_ff);
            s5_in.kind[0]  = ppd_pkg::KIND_I;
         end
         ppd_pkg::MODE_LINEAR: begin
            s5_in.count    = ppd_pkg::CNT_W'(2);
            s5_in.value[0] = ppd_pkg::clamp_value(s4_px_ff);
            s5_in.kind[0]  = ppd_pkg::KIND_XX;
            s5_in.value[1] = ppd_pkg::clamp_value(s4_py_ff);
            s5_in.kind[1]  = ppd_pkg::KIND_YY;
         end
         ppd_pkg::MODE_CIRCULAR: begin
            // magnitudes are never negative: the floor shift drops the low bit
            s5_in.count    = ppd_pkg::CNT_W'(2);
            s5_in.value[0] = ppd_pkg::clamp_value(s4_lm_ff >>> 1);
            s5_in.kind[0]  = ppd_pkg::KIND_LL;
            s5_in.value[1] = ppd_pkg::clamp_value(s4_rm_ff >>> 1);
            s5_in.kind[1]  = ppd_pkg::KIND_RR;
         end
         ppd_pkg::MODE_STOKES: begin
            s5_in.count    = ppd_pkg::CNT_W'(4);
            s5_in.value[0] = ppd_pkg::clamp_value(s4_px_ff + s4_py_ff);
            s5_in.kind[0]  = ppd_pkg::KIND_I;
            s5_in.value[1] = ppd_pkg::clamp_value(s4_px_ff - s4_py_ff);
            s5_in.kind[1]  = ppd_pkg::KIND_Q;
            s5_in.value[2] = ppd_pkg::clamp_value(s4_re_ff <<< 1);
            s5_in.kind[2]  = ppd_pkg::KIND_U;
            s5_in.value[3] = ppd_pkg::clamp_value(-(s4_im_ff <<< 1));
            s5_in.kind[3]  = ppd_pkg::KIND_V;
         end
         default: begin
            s5_in.count = '0;
         end
      endcase
   end

   assign result_set = s5_ff;

endmodule

// File: sv/ppd_serializer.sv
// Output buffer that shifts out the results of one sample, one item per cycle while out_ready is high.
module ppd_serializer (
   input  logic                              clock,
   input  logic                              reset,
   input  ppd_pkg::result_set_type           result_set,
   output logic                              ready,
   output logic                              out_valid,
   input  logic                              out_ready,
   output logic [ppd_pkg::VALUE_W-1:0]       out_value,
   output ppd_pkg::kind_type                 out_kind,
   output logic                              out_last
);

   localparam int N = ppd_pkg::MAX_RESULTS;

   logic [ppd_pkg::CNT_W-1:0]  count_ff, count_in;
   logic [ppd_pkg::VALUE_W-1:0] value_ff [N];
   logic [ppd_pkg::KIND_W-1:0]  kind_ff  [N];
   logic                        load, take;

   assign out_valid = (count_ff != '0);
   assign out_last  = (count_ff == ppd_pkg::CNT_W'(1));
   assign take      = out_valid && out_ready;
   // Free now, or free once the last buffered item leaves this cycle.
   assign ready     = (count_ff == '0) || (out_last && out_ready);
   assign load      = result_set.valid && ready;

   always_comb begin
      count_in = count_ff;
      if (load) begin
         count_in = result_set.count;
      end else if (take) begin
         count_in = count_ff - ppd_pkg::CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         for (int i = 0; i < N; i++) begin
            value_ff[i] <= result_set.value[i];
            kind_ff[i]  <= result_set.kind[i];
         end
      end else if (take) begin
         // advance the queue toward slot zero
         for (int i = 0; i < N - 1; i++) begin
            value_ff[i] <= value_ff[i+1];
            kind_ff[i]  <= kind_ff[i+1];
         end
      end
   end

   assign out_value = value_ff[0];
   assign out_kind  = kind_ff[0];

endmodule
